FILE: rtl/sspq_pkg.sv
package sspq_pkg;

  // Field widths fixed by the channel definitions
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 33;
  localparam int PER_W   = 10;
  localparam int LEVEL_W = 3;
  localparam int TAG_W   = 16;

  localparam logic [PER_W-1:0] PER_RESET = 10'd5;

  // Remainder unit: bits retired per cycle and number of rounds
  localparam int DIV_STEPS  = 4;
  localparam int DIV_ROUNDS = TIME_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_ROUNDS);

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_FLUSH   = 1'b1;

  localparam logic KIND_SERVED = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic pop;   // shift every cell toward the head
    logic push;  // insert the new entry at its ordered place
  } cell_ctl_t;

endpackage

FILE: rtl/sspq_if.sv
interface sspq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [sspq_pkg::TIME_W-1:0]       arrival_time;
  logic [sspq_pkg::LEVEL_W-1:0]      level;
  logic [sspq_pkg::TAG_W-1:0]        tag;

  modport source (output valid, cmd, arrival_time, level, tag, input ready);
  modport sink   (input valid, cmd, arrival_time, level, tag, output ready);
endinterface

interface sspq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [sspq_pkg::TAG_W-1:0]        served_tag;
  logic                              last;

  modport source (output valid, kind, served_tag, last, input ready);
  modport sink   (input valid, kind, served_tag, last, output ready);
endinterface

interface sspq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sspq_pkg::PER_W-1:0]        slot_period;

  modport source (output valid, slot_period, input ready);
  modport sink   (input valid, slot_period, output ready);
endinterface

FILE: rtl/sspq_cell.sv
module sspq_cell #(
  parameter int LW = 2,
  parameter int TW = 16
) (
  input  logic                clk,
  input  sspq_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  logic [LW-1:0]       new_lvl,
  input  logic [TW-1:0]       new_tag,
  input  logic                left_ge,
  input  logic [LW-1:0]       left_lvl,
  input  logic [TW-1:0]       left_tag,
  input  logic [LW-1:0]       right_lvl,
  input  logic [TW-1:0]       right_tag,
  output logic [LW-1:0]       lvl,
  output logic [TW-1:0]       tag,
  output logic                ge
);

  logic [LW-1:0] lvl_r;
  logic [TW-1:0] tag_r;

  // Entry stays ahead of the newcomer when it is at the same or a higher level
  assign ge  = occ && (lvl_r >= new_lvl);
  assign lvl = lvl_r;
  assign tag = tag_r;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      lvl_r <= right_lvl;
      tag_r <= right_tag;
    end else if (ctl.push && !ge) begin
      if (left_ge) begin
        lvl_r <= new_lvl;
        tag_r <= new_tag;
      end else begin
        lvl_r <= left_lvl;
        tag_r <= left_tag;
      end
    end
  end

endmodule

FILE: rtl/sspq_rem.sv
module sspq_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sspq_pkg::TIME_W-1:0]   dividend,
  input  logic [sspq_pkg::PER_W-1:0]    divisor,
  output logic                          done,
  output logic [sspq_pkg::PER_W-1:0]    rem
);

  logic [sspq_pkg::TIME_W-1:0]    d_r;
  logic [sspq_pkg::PER_W-1:0]     rem_r;
  logic [sspq_pkg::PER_W-1:0]     rem_nxt;
  logic [sspq_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  // Retire DIV_STEPS dividend bits, restoring form
  always_comb begin
    logic [sspq_pkg::PER_W:0] w;
    rem_nxt = rem_r;
    for (int j = 0; j < sspq_pkg::DIV_STEPS; j++) begin
      w = {rem_nxt, d_r[sspq_pkg::TIME_W-1-j]};
      if (w >= {1'b0, divisor}) begin
        w = w - {1'b0, divisor};
      end
      rem_nxt = w[sspq_pkg::PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == sspq_pkg::DIV_CNT_W'(sspq_pkg::DIV_ROUNDS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      d_r   <= d_r << sspq_pkg::DIV_STEPS;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/slotted_strict_priority_queue.sv
// Strict priority queue with LEVELS levels and first-come order within a level,
// served in time slots that fall every slot_period ticks from tick 0. An arrival
// first runs every slot strictly before its arrival time, one transfer on the
// out channel per served entry (highest level, oldest first), then stores the
// entry, or answers with a single reject transfer (kind 1, its own tag) when
// CAPACITY entries are already queued. A flush transfers every entry in service
// order. The final transfer caused by an input carries last. A slot_period of 0
// acts as 1; a level of 0 acts as 1 and a level above LEVELS acts as LEVELS.
// Items are taken one at a time. When the queue runs dry while slots remain,
// the slot clock is realigned by a remainder unit that retires four bits of
// the 32-bit time gap per cycle. Each served entry waits while the out
// channel stalls. Entries live in a row of CAPACITY cells kept in service
// order; the head cell feeds the output and an insert opens a gap at the
// entry's place. slot_period may be written only while the block is idle.
module slotted_strict_priority_queue #(
  parameter int CAPACITY = 64,
  parameter int LEVELS   = 4,
  parameter int TAG_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  sspq_in_if.sink      in_chan,
  sspq_out_if.source   out_chan,
  sspq_cfg_if.sink     cfg_chan
);

  localparam int LW = $clog2(LEVELS);
  localparam int TW = (TAG_BITS < sspq_pkg::TAG_W) ? TAG_BITS : sspq_pkg::TAG_W;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SERVE = 5'b00010,
    S_REM   = 5'b00100,
    S_FIN   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Held input item
  logic [sspq_pkg::TIME_W-1:0]  t_r;
  logic [LW-1:0]                lvl_r;
  logic [TW-1:0]                tag_r;

  logic [sspq_pkg::SLOT_W-1:0]  next_r, next_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [sspq_pkg::PER_W-1:0]   per_r;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [sspq_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         out_free;
  logic [sspq_pkg::SLOT_W-1:0]  t_ext;
  logic [sspq_pkg::SLOT_W-1:0]  nsum;
  logic                         slot_due;
  logic                         serve_ok;
  logic                         full;
  logic                         rem_start;
  logic                         rem_done;
  logic [sspq_pkg::PER_W-1:0]   rem_val;
  logic [sspq_pkg::PER_W-1:0]   pad;
  logic [LW-1:0]                in_lvl_idx;
  sspq_pkg::cell_ctl_t          ctl;

  logic [LW-1:0]                cell_lvl [CAPACITY];
  logic [TW-1:0]                cell_tag [CAPACITY];
  logic                         cell_ge  [CAPACITY];
  logic                         cell_occ [CAPACITY];

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.served_tag = out_tag_r;
  assign out_chan.last       = out_last_r;

  assign out_free = !out_valid_r || out_chan.ready;
  assign t_ext    = {1'b0, t_r};
  assign nsum     = next_r + {{(sspq_pkg::SLOT_W - sspq_pkg::PER_W){1'b0}}, per_r};
  assign slot_due = next_r < t_ext;
  assign serve_ok = slot_due && (count_r != '0);
  assign full     = (count_r == CW'(CAPACITY));
  assign pad      = (rem_val == '0) ? '0 : per_r - rem_val;

  // Clamp the level into range and turn it into a zero-based index
  always_comb begin
    if (in_chan.level == '0) begin
      in_lvl_idx = '0;
    end else if (int'(in_chan.level) > LEVELS) begin
      in_lvl_idx = LW'(LEVELS - 1);
    end else begin
      in_lvl_idx = LW'(in_chan.level - 1'b1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    next_nxt      = next_r;
    count_nxt     = count_r;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ctl           = '0;
    rem_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (in_chan.cmd == sspq_pkg::CMD_FLUSH) ? S_FLUSH : S_SERVE;
        end
      end
      S_SERVE: begin
        if (serve_ok) begin
          if (out_free) begin
            ctl.pop       = 1'b1;
            count_nxt     = count_r - 1'b1;
            next_nxt      = nsum;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sspq_pkg::KIND_SERVED;
            out_tag_nxt   = sspq_pkg::TAG_W'(cell_tag[0]);
            // Last when the next slot is not due or the queue runs dry
            out_last_nxt  = !(nsum < t_ext) || (count_r == CW'(1));
          end
        end else if (slot_due) begin
          rem_start = 1'b1;
          state_nxt = S_REM;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_REM: begin
        // Jump to the first slot at or after the arrival
        if (rem_done) begin
          next_nxt  = t_ext + {{(sspq_pkg::SLOT_W - sspq_pkg::PER_W){1'b0}}, pad};
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (full) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sspq_pkg::KIND_REJECT;
            out_tag_nxt   = sspq_pkg::TAG_W'(tag_r);
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          ctl.push  = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (count_r == '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ctl.pop       = 1'b1;
          count_nxt     = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sspq_pkg::KIND_SERVED;
          out_tag_nxt   = sspq_pkg::TAG_W'(cell_tag[0]);
          out_last_nxt  = (count_r == CW'(1));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      per_r       <= sspq_pkg::PER_RESET;
    end else begin
      state_r     <= state_nxt;
      next_r      <= next_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      // Hold the effective period: zero acts as one
      if (cfg_chan.valid) begin
        per_r <= (cfg_chan.slot_period == '0) ? sspq_pkg::PER_W'(1) : cfg_chan.slot_period;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
    if (in_chan.valid && in_chan.ready) begin
      t_r   <= in_chan.arrival_time;
      lvl_r <= in_lvl_idx;
      tag_r <= in_chan.tag[TW-1:0];
    end
  end

  sspq_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (t_r - next_r[sspq_pkg::TIME_W-1:0]),
    .divisor  (per_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Row of cells in service order; cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          l_ge;
    logic [LW-1:0] l_lvl;
    logic [TW-1:0] l_tag;
    logic [LW-1:0] r_lvl;
    logic [TW-1:0] r_tag;

    assign cell_occ[i] = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign l_ge  = 1'b1;
      assign l_lvl = lvl_r;
      assign l_tag = tag_r;
    end else begin : g_body
      assign l_ge  = cell_ge[i-1];
      assign l_lvl = cell_lvl[i-1];
      assign l_tag = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_lvl = cell_lvl[i];
      assign r_tag = cell_tag[i];
    end else begin : g_inner
      assign r_lvl = cell_lvl[i+1];
      assign r_tag = cell_tag[i+1];
    end

    sspq_cell #(
      .LW (LW),
      .TW (TW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (cell_occ[i]),
      .new_lvl   (lvl_r),
      .new_tag   (tag_r),
      .left_ge   (l_ge),
      .left_lvl  (l_lvl),
      .left_tag  (l_tag),
      .right_lvl (r_lvl),
      .right_tag (r_tag),
      .lvl       (cell_lvl[i]),
      .tag       (cell_tag[i]),
      .ge        (cell_ge[i])
    );
  end

endmodule

FILE: rtl/sspq_checker.sv
module sspq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [sspq_pkg::TAG_W-1:0]  out_tag,
  input logic                        out_last
);

  // Block takes one item at a time: drop ready right after a transfer in
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // A reject is the only result of its arrival, so it must carry last
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == sspq_pkg::KIND_REJECT) |-> out_last)
    else $error("reject result without last");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tag)
      && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind slotted_strict_priority_queue sspq_checker u_sspq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.kind),
  .out_tag   (out_chan.served_tag),
  .out_last  (out_chan.last)
);
